>>> sv/medh_pkg.sv
// Package: shared constants, word types and helper functions for the edge de-duplication hash.
package medh_pkg;

  localparam int DIRECT_BUCKETS = 4096;
  localparam int TABLE_FACTOR   = 7;
  localparam int VERTEX_BITS    = 31;
  localparam int TABLE_DEPTH    = TABLE_FACTOR * DIRECT_BUCKETS;
  localparam int ADDR_W         = $clog2(TABLE_DEPTH);
  localparam int KEY_W          = $clog2(DIRECT_BUCKETS);
  localparam int SIZE_W         = KEY_W + 1;
  localparam int CFG_W          = 13;
  localparam int SUM_W          = VERTEX_BITS + 3;
  localparam int DIV_STEPS      = (SUM_W + 1) / 2;
  localparam int SHIFT_W        = 2 * DIV_STEPS;
  localparam int STEP_W         = $clog2(DIV_STEPS);
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

  typedef logic [VERTEX_BITS-1:0] vertex_t;

  typedef struct packed {
    vertex_t vertex_a;
    vertex_t vertex_b;
    vertex_t vertex_c;
    vertex_t vertex_d;
  } in_t;

  typedef struct packed {
    logic [30:0] edge_low;
    logic [30:0] edge_high;
    logic        edge_valid;
    logic        table_full;
    logic        last;
  } out_t;

  // One word of the queue between the front and back parts.
  typedef struct packed {
    vertex_t          lo;
    vertex_t          hi;
    logic [KEY_W-1:0] key;
    logic             is_edge;
    logic             last_edge;
  } qent_t;

  // One bucket of the table.
  typedef struct packed {
    vertex_t           low;
    vertex_t           high;
    logic [ADDR_W-1:0] link;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Effective number of direct buckets for a written register value.
  function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] value);
    logic [SIZE_W-1:0] res;
    if (value == '0) begin
      res = SIZE_W'(1);
    end else if (32'(value) > DIRECT_BUCKETS) begin
      res = SIZE_W'(DIRECT_BUCKETS);
    end else begin
      res = SIZE_W'(value);
    end
    return res;
  endfunction

  // Vertex positions of the two ends of each edge of the tetrahedron.
  function automatic logic [1:0] edge_end_x(input logic [2:0] j);
    logic [1:0] res;
    case (j)
      3'd0: res = 2'd0;
      3'd1: res = 2'd1;
      3'd2: res = 2'd2;
      default: res = 2'd3;
    endcase
    return res;
  endfunction

  function automatic logic [1:0] edge_end_y(input logic [2:0] j);
    logic [1:0] res;
    case (j)
      3'd0: res = 2'd1;
      3'd1: res = 2'd2;
      3'd2: res = 2'd0;
      3'd3: res = 2'd0;
      3'd4: res = 2'd1;
      default: res = 2'd2;
    endcase
    return res;
  endfunction

endpackage

>>> sv/mesh_edge_dedup_hash.sv
// Top level of the edge de-duplication hash: configuration register, front, queue and back.
// Front: each edge with both ends non-zero goes through select, the remainder steps and push,
// a skipped edge through select only. Back: reads each bucket of the chain in turn, then
// inserts or drops the edge. Synchronous reset and every configuration write start a clearing
// pass over the direct buckets; no tetrahedron is taken during it.
module mesh_edge_dedup_hash (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  medh_pkg::in_t       in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output medh_pkg::out_t      out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [12:0]         cfg_data
);

  // The hash_size register as written, and the bucket count it stands for.
  logic [medh_pkg::CFG_W-1:0]  hash_size;
  logic [medh_pkg::SIZE_W-1:0] size;

  logic            push;
  medh_pkg::qent_t push_data;
  logic            pop;
  medh_pkg::qent_t head;
  logic            q_full;
  logic            q_empty;
  logic            clearing;
  logic            cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign size      = medh_pkg::eff_size(hash_size);

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_size <= medh_pkg::CFG_W'(medh_pkg::DIRECT_BUCKETS);
    end else if (cfg_write) begin
      hash_size <= cfg_data;
    end
  end

  // The front works out each edge's bucket key while the back is busy with the chain walk
  // of an earlier edge; the queue lets either side stall without holding up the other.
  medh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .hold      (clearing),
    .size      (size),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  medh_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // The back holds each new edge back by one so that the last flag can be set on the
  // final edge of a tetrahedron, or an empty word sent when nothing was added.
  medh_back u_back (
    .clk       (clk),
    .rst       (rst),
    .init      (cfg_write),
    .init_size (medh_pkg::eff_size(cfg_data)),
    .size      (size),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTH
  // The front never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("edge word pushed into a full queue");

  // Nothing is taken from the queue while the table is being cleared.
  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst) clearing |-> !pop)
    else $error("queue popped during clearing pass");

  // Reset always starts a clearing pass, and no tetrahedron is taken during it.
  a_reset_clear: assert property (@(posedge clk) rst |=> clearing && !in_ready)
    else $error("reset did not start clearing pass");
`endif

endmodule

>>> sv/medh_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module medh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/medh_queue.sv
// Short queue of edge words between the front and back parts.
module medh_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  medh_pkg::qent_t push_data,
  input  logic           pop,
  output medh_pkg::qent_t head,
  output logic           full,
  output logic           empty
);

  medh_pkg::qent_t slots [medh_pkg::QUEUE_DEPTH];
  logic [medh_pkg::QPTR_W-1:0] rd_ptr;
  logic [medh_pkg::QPTR_W-1:0] wr_ptr;
  logic [medh_pkg::QPTR_W:0]   count;
  logic do_push;
  logic do_pop;

  assign full    = (count == (medh_pkg::QPTR_W+1)'(medh_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> sv/medh_front.sv
// Front part: takes a tetrahedron, forms its edges and computes each bucket key.
module medh_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  medh_pkg::in_t                 in_data,
  input  logic                          hold,
  input  logic [medh_pkg::SIZE_W-1:0]   size,
  output logic                          push,
  output medh_pkg::qent_t               push_data,
  input  logic                          q_full
);

  typedef enum logic [1:0] {F_IDLE, F_SEL, F_DIV, F_PUSH} fstate_t;

  fstate_t state;
  medh_pkg::in_t verts;
  logic [5:0] mask;
  logic [2:0] j;
  logic marker;
  medh_pkg::vertex_t lo;
  medh_pkg::vertex_t hi;
  logic [medh_pkg::SHIFT_W-1:0] sum_sh;
  logic [medh_pkg::SIZE_W-1:0] rem;
  logic [medh_pkg::STEP_W-1:0] step;

  logic [5:0] in_mask;
  medh_pkg::vertex_t x;
  medh_pkg::vertex_t y;
  medh_pkg::vertex_t cur_lo;
  medh_pkg::vertex_t cur_hi;
  logic [medh_pkg::SUM_W-1:0] sum;
  logic [medh_pkg::SIZE_W-1:0] rem_next;
  logic [medh_pkg::SIZE_W-1:0] r1;
  logic [medh_pkg::SIZE_W-1:0] r2;
  logic [5:0] above;

  function automatic medh_pkg::vertex_t pick(input medh_pkg::in_t v, input logic [1:0] k);
    medh_pkg::vertex_t res;
    case (k)
      2'd0: res = v.vertex_a;
      2'd1: res = v.vertex_b;
      2'd2: res = v.vertex_c;
      default: res = v.vertex_d;
    endcase
    return res;
  endfunction

  // An edge can only be stored when both its ends are non-zero.
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      in_mask[k] = (pick(in_data, medh_pkg::edge_end_x(3'(k))) != '0) &&
                   (pick(in_data, medh_pkg::edge_end_y(3'(k))) != '0);
    end
  end

  assign x      = pick(verts, medh_pkg::edge_end_x(j));
  assign y      = pick(verts, medh_pkg::edge_end_y(j));
  assign cur_lo = (x < y) ? x : y;
  assign cur_hi = (x < y) ? y : x;
  assign sum    = ({3'b000, cur_lo} + {2'b00, cur_lo, 1'b0}) +
                  ({3'b000, cur_hi} + {1'b0, cur_hi, 2'b00});

  // Two restoring remainder steps per cycle.
  always_comb begin
    r1 = {rem[medh_pkg::SIZE_W-2:0], sum_sh[medh_pkg::SHIFT_W-1]};
    if (r1 >= size) begin
      r1 = r1 - size;
    end
    r2 = {r1[medh_pkg::SIZE_W-2:0], sum_sh[medh_pkg::SHIFT_W-2]};
    if (r2 >= size) begin
      r2 = r2 - size;
    end
    rem_next = r2;
  end

  assign above     = mask >> (4'(j) + 4'd1);
  assign in_ready  = (state == F_IDLE) && !hold;
  assign push      = (state == F_PUSH) && !q_full;
  assign push_data = '{lo: lo, hi: hi, key: rem[medh_pkg::KEY_W-1:0],
                       is_edge: !marker, last_edge: marker || (above == '0)};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid && in_ready) begin
            verts  <= in_data;
            mask   <= in_mask;
            j      <= '0;
            marker <= (in_mask == '0);
            lo     <= '0;
            hi     <= '0;
            rem    <= '0;
            state  <= (in_mask == '0) ? F_PUSH : F_SEL;
          end
        end
        F_SEL: begin
          if (mask[j]) begin
            lo     <= cur_lo;
            hi     <= cur_hi;
            sum_sh <= medh_pkg::SHIFT_W'(sum);
            rem    <= '0;
            step   <= '0;
            state  <= F_DIV;
          end else begin
            j <= j + 1'b1;
          end
        end
        F_DIV: begin
          rem    <= rem_next;
          sum_sh <= sum_sh << 2;
          step   <= step + 1'b1;
          if (step == medh_pkg::STEP_W'(medh_pkg::DIV_STEPS - 1)) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            if (push_data.last_edge) begin
              state <= F_IDLE;
            end else begin
              j     <= j + 1'b1;
              state <= F_SEL;
            end
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

>>> sv/medh_back.sv
// Back part: walks bucket chains, inserts new edges and drives the result words.
module medh_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          init,
  input  logic [medh_pkg::SIZE_W-1:0]   init_size,
  input  logic [medh_pkg::SIZE_W-1:0]   size,
  input  medh_pkg::qent_t               head,
  input  logic                          q_empty,
  output logic                          pop,
  output logic                          clearing,
  output logic                          out_valid,
  input  logic                          out_ready,
  output medh_pkg::out_t                out_data
);

  typedef enum logic [2:0] {B_IDLE, B_READ, B_CHECK, B_WR2, B_FIN} bstate_t;

  bstate_t state;
  medh_pkg::vertex_t lo;
  medh_pkg::vertex_t hi;
  logic [medh_pkg::ADDR_W-1:0] addr;
  logic [medh_pkg::ADDR_W-1:0] new_slot;
  logic [medh_pkg::ADDR_W-1:0] next_free;
  logic [medh_pkg::KEY_W-1:0]  clr_addr;
  logic end_flag;
  logic have_new;
  logic new_full;
  logic pend_valid;
  medh_pkg::out_t pend;

  logic we;
  logic [medh_pkg::ADDR_W-1:0] waddr;
  medh_pkg::entry_t wdata;
  logic [medh_pkg::ENTRY_W-1:0] rd_word;
  medh_pkg::entry_t rd;
  logic [medh_pkg::ADDR_W-1:0] limit;
  logic out_free;
  logic match;
  medh_pkg::out_t new_res;

  assign rd       = medh_pkg::entry_t'(rd_word);
  assign limit    = medh_pkg::ADDR_W'(medh_pkg::TABLE_FACTOR) * medh_pkg::ADDR_W'(size);
  assign out_free = !out_valid || out_ready;
  assign match    = (rd.low == lo) && (rd.high == hi);
  assign pop      = (state == B_IDLE) && !clearing && !q_empty;
  assign new_res  = '{edge_low: 31'(lo), edge_high: 31'(hi), edge_valid: 1'b1,
                      table_full: new_full, last: 1'b0};

  // Write port: the clearing pass, an empty direct bucket, a link update or a new chain entry.
  always_comb begin
    we    = 1'b0;
    waddr = addr;
    wdata = '{low: lo, high: hi, link: '0};
    if (clearing) begin
      we    = 1'b1;
      waddr = medh_pkg::ADDR_W'(clr_addr);
      wdata = '0;
    end else if (state == B_CHECK) begin
      if (rd.low == '0) begin
        we = 1'b1;
      end else if (!match && rd.link == '0 && next_free < limit) begin
        we    = 1'b1;
        wdata = '{low: rd.low, high: rd.high, link: next_free};
      end
    end else if (state == B_WR2) begin
      we    = 1'b1;
      waddr = new_slot;
    end
  end

  medh_ram #(.WIDTH(medh_pkg::ENTRY_W), .DEPTH(medh_pkg::TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (state == B_READ),
    .raddr (addr),
    .rdata (rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      clearing   <= 1'b1;
      clr_addr   <= '0;
      next_free  <= medh_pkg::ADDR_W'(medh_pkg::DIRECT_BUCKETS);
      pend_valid <= 1'b0;
      have_new   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (init) begin
        clearing  <= 1'b1;
        clr_addr  <= '0;
        next_free <= medh_pkg::ADDR_W'(init_size);
      end else if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == '1) begin
          clearing <= 1'b0;
        end
      end
      case (state)
        B_IDLE: begin
          if (pop) begin
            lo       <= head.lo;
            hi       <= head.hi;
            addr     <= medh_pkg::ADDR_W'(head.key);
            end_flag <= head.last_edge;
            have_new <= 1'b0;
            state    <= head.is_edge ? B_READ : B_FIN;
          end
        end
        B_READ: state <= B_CHECK;
        B_CHECK: begin
          if (rd.low == '0) begin
            have_new <= 1'b1;
            new_full <= 1'b0;
            state    <= B_FIN;
          end else if (match) begin
            state <= B_FIN;
          end else if (rd.link != '0) begin
            addr  <= rd.link;
            state <= B_READ;
          end else if (next_free >= limit) begin
            have_new <= 1'b1;
            new_full <= 1'b1;
            state    <= B_FIN;
          end else begin
            new_slot  <= next_free;
            next_free <= next_free + 1'b1;
            state     <= B_WR2;
          end
        end
        B_WR2: begin
          have_new <= 1'b1;
          new_full <= 1'b0;
          state    <= B_FIN;
        end
        B_FIN: begin
          if (have_new) begin
            if (!pend_valid) begin
              pend       <= new_res;
              pend_valid <= 1'b1;
              have_new   <= 1'b0;
            end else if (out_free) begin
              out_valid <= 1'b1;
              out_data  <= pend;
              pend      <= new_res;
              have_new  <= 1'b0;
            end
          end else if (!end_flag) begin
            state <= B_IDLE;
          end else if (out_free) begin
            out_valid  <= 1'b1;
            out_data   <= pend_valid ? medh_pkg::out_t'{edge_low: pend.edge_low,
                                                        edge_high: pend.edge_high,
                                                        edge_valid: 1'b1,
                                                        table_full: pend.table_full,
                                                        last: 1'b1}
                                     : medh_pkg::out_t'{edge_low: '0, edge_high: '0,
                                                        edge_valid: 1'b0,
                                                        table_full: 1'b0, last: 1'b1};
            pend_valid <= 1'b0;
            state      <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

>>> tb/tb_mesh_edge_dedup_hash.sv
// Self-checking testbench for the tetrahedron edge de-duplication hash.
`timescale 1ns / 1ps

module tb_mesh_edge_dedup_hash;

  localparam int CLK_HALF     = 10;
  localparam int SETTLE_LEN   = 300;
  localparam int ITEMS_PHASE  = 60;
  localparam logic [30:0] VMAX = 31'h7FFF_FFFF;

  logic           clk;
  logic           rst;
  logic           in_valid;
  logic           in_ready;
  medh_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_ready;
  medh_pkg::out_t out_data;
  logic           cfg_valid;
  logic           cfg_ready;
  logic [12:0]    cfg_data;

  mesh_edge_dedup_hash i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Our own copy of the bucket table, kept in step with every accepted word.
  logic [30:0]       shadow_low  [medh_pkg::TABLE_DEPTH];
  logic [30:0]       shadow_high [medh_pkg::TABLE_DEPTH];
  int unsigned       shadow_link [medh_pkg::TABLE_DEPTH];
  int unsigned       shadow_free;
  int unsigned       shadow_size;

  // Edge words that the block still owes us, oldest first.
  medh_pkg::out_t pending_edges[$];

  int            mismatches;
  bit            in_burst;
  bit            out_burst;
  medh_pkg::in_t last_tetra;

  typedef enum int {INS_DUP, INS_STORED, INS_FULL} insert_t;

  // One row of the directed part. Where want_typed is set, the row yields exactly one
  // word and its value is written out here instead of taken from the shadow table.
  typedef struct {
    logic [30:0]    a, b, c, d;
    bit             want_typed;
    medh_pkg::out_t want;
  } stim_row_t;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Generous fixed bound on the whole run, including the clearing passes.
  initial begin
    #100ms;
    $display("tb_mesh_edge_dedup_hash NOT OK");
    $finish;
  end

  // The register value is masked to 13 bits; zero and values above the direct area clamp.
  function automatic int unsigned clamp_size(input logic [12:0] value);
    if (value == 13'd0) return 1;
    if (int'(value) > medh_pkg::DIRECT_BUCKETS) return medh_pkg::DIRECT_BUCKETS;
    return int'(value);
  endfunction

  task automatic wipe_shadow(input logic [12:0] value);
    for (int i = 0; i < medh_pkg::TABLE_DEPTH; i++) begin
      shadow_low[i]  = '0;
      shadow_high[i] = '0;
      shadow_link[i] = 0;
    end
    shadow_size = clamp_size(value);
    shadow_free = shadow_size;
  endtask

  // Insert one ordered edge into the shadow table, walking its chain as the block does.
  function automatic insert_t shadow_insert(input logic [30:0] lo, input logic [30:0] hi);
    int unsigned key;
    int unsigned nxt;
    int unsigned limit;
    limit = medh_pkg::TABLE_FACTOR * shadow_size;
    key   = (3 * (int'(lo) % shadow_size) + 5 * (int'(hi) % shadow_size)) % shadow_size;
    if (shadow_low[key] == '0) begin
      shadow_low[key]  = lo;
      shadow_high[key] = hi;
      shadow_link[key] = 0;
      return INS_STORED;
    end
    forever begin
      if (shadow_low[key] == lo && shadow_high[key] == hi) return INS_DUP;
      nxt = shadow_link[key];
      if (nxt != 0) begin
        key = nxt;
      end else begin
        if (shadow_free >= limit || shadow_free >= medh_pkg::TABLE_DEPTH) return INS_FULL;
        shadow_link[key] = shadow_free;
        key              = shadow_free;
        shadow_free++;
        shadow_low[key]  = lo;
        shadow_high[key] = hi;
        shadow_link[key] = 0;
        return INS_STORED;
      end
    end
  endfunction

  // Work out the words for one tetrahedron and queue them.
  task automatic predict_edges(input medh_pkg::in_t tet);
    logic [30:0]    vert [4];
    logic [30:0]    x, y, lo, hi;
    insert_t        res;
    medh_pkg::out_t word;
    int             first;
    int             xs [6];
    int             ys [6];
    xs = '{0, 1, 2, 3, 3, 3};
    ys = '{1, 2, 0, 0, 1, 2};
    vert[0] = tet.vertex_a;
    vert[1] = tet.vertex_b;
    vert[2] = tet.vertex_c;
    vert[3] = tet.vertex_d;
    first = pending_edges.size();
    for (int j = 0; j < 6; j++) begin
      x  = vert[xs[j]];
      y  = vert[ys[j]];
      lo = (x < y) ? x : y;
      hi = (x < y) ? y : x;
      if (lo != '0) begin
        res = shadow_insert(lo, hi);
        if (res != INS_DUP) begin
          word.edge_low   = lo;
          word.edge_high  = hi;
          word.edge_valid = 1'b1;
          word.table_full = (res == INS_FULL);
          word.last       = 1'b0;
          pending_edges.push_back(word);
        end
      end
    end
    if (pending_edges.size() == first) begin
      // Nothing new: a single empty word closes the tetrahedron.
      word = '0;
      word.last = 1'b1;
      pending_edges.push_back(word);
    end else begin
      pending_edges[pending_edges.size()-1].last = 1'b1;
    end
  endtask

  // Offer one tetrahedron and hold it until the block takes it. The valid line is only
  // lowered when a gap is drawn, so back-to-back words never see a second assignment.
  task automatic send_tetra(input medh_pkg::in_t tet);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= tet;
    predict_edges(tet);
    last_tetra = tet;
    do @(posedge clk); while (!in_ready);
  endtask

  // Let the block drain fully before touching the register, then write it.
  task automatic write_hash_size(input logic [12:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_edges.size() == 0);
    repeat (SETTLE_LEN) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    wipe_shadow(value);
  endtask

  function automatic logic [30:0] any_vertex();
    logic [30:0] v;
    do v = 31'($urandom()); while (v == '0);
    return v;
  endfunction

  // Random tetrahedra. Most draw from a small pool so that edges repeat, chains grow and
  // the overflow area fills at small sizes; the rest are wide values, repeated corners and
  // permutations of the previous tetrahedron.
  function automatic medh_pkg::in_t random_tetra(input int pool);
    medh_pkg::in_t t;
    int            mode;
    mode = $urandom_range(0, 9);
    t.vertex_a = 31'($urandom_range(1, pool));
    t.vertex_b = 31'($urandom_range(1, pool));
    t.vertex_c = 31'($urandom_range(1, pool));
    t.vertex_d = 31'($urandom_range(1, pool));
    case (mode)
      7: begin
        t.vertex_a = any_vertex();
        t.vertex_b = any_vertex();
        t.vertex_c = any_vertex();
        t.vertex_d = any_vertex();
      end
      8: begin
        t.vertex_c = t.vertex_a;
        t.vertex_d = ($urandom_range(0, 1) != 0) ? t.vertex_b : t.vertex_a;
      end
      9: begin
        t.vertex_a = last_tetra.vertex_d;
        t.vertex_b = last_tetra.vertex_c;
        t.vertex_c = last_tetra.vertex_b;
        t.vertex_d = last_tetra.vertex_a;
      end
      default: ;
    endcase
    return t;
  endfunction

  // Receiver: stalls at random, compares every accepted word with the oldest expectation.
  initial begin
    medh_pkg::out_t want;
    int             gap;
    out_ready <= 1'b0;
    @(negedge rst);
    forever begin
      gap = out_burst ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_edges.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected edge word: low=%h high=%h valid=%b full=%b last=%b",
                   out_data.edge_low, out_data.edge_high, out_data.edge_valid,
                   out_data.table_full, out_data.last);
      end else begin
        want = pending_edges.pop_front();
        if (out_data.edge_low !== want.edge_low || out_data.edge_high !== want.edge_high ||
            out_data.edge_valid !== want.edge_valid ||
            out_data.table_full !== want.table_full || out_data.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("edge word mismatch: want %h/%h v%b f%b l%b, got %h/%h v%b f%b l%b",
                     want.edge_low, want.edge_high, want.edge_valid, want.table_full,
                     want.last, out_data.edge_low, out_data.edge_high,
                     out_data.edge_valid, out_data.table_full, out_data.last);
        end
      end
    end
  end

  // Flip between idling and back-to-back stretches on both sides.
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) in_burst  <= ~in_burst;
    if ($urandom_range(0, 63) == 0) out_burst <= ~out_burst;
  end

  initial begin
    stim_row_t     rows [$];
    stim_row_t     r;
    medh_pkg::in_t tet;
    logic [12:0]   sizes [7];
    int            pools [7];
    int            waited;
    sizes = '{13'd1, 13'd0, 13'd3, 13'd8191, 13'd4096, 13'd37, 13'd16};
    pools = '{12, 10, 20, 60, 80, 40, 30};
    mismatches = 0;
    in_burst   = 1'b0;
    out_burst  = 1'b0;
    last_tetra = '{31'd1, 31'd2, 31'd3, 31'd4};
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    wipe_shadow(13'd4096);
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset size of 4096 buckets.
    rows.push_back('{31'd5, 31'd5, 31'd5, 31'd5, 1'b1, '{31'd5, 31'd5, 1'b1, 1'b0, 1'b1}});
    rows.push_back('{31'd5, 31'd5, 31'd5, 31'd5, 1'b1, '{31'd0, 31'd0, 1'b0, 1'b0, 1'b1}});
    rows.push_back('{VMAX, VMAX, VMAX, VMAX, 1'b1, '{VMAX, VMAX, 1'b1, 1'b0, 1'b1}});
    rows.push_back('{31'd1, 31'd2, 31'd3, 31'd4, 1'b0, '0});
    rows.push_back('{31'd1, 31'd2, 31'd3, 31'd4, 1'b1, '{31'd0, 31'd0, 1'b0, 1'b0, 1'b1}});
    rows.push_back('{31'd4, 31'd3, 31'd2, 31'd1, 1'b1, '{31'd0, 31'd0, 1'b0, 1'b0, 1'b1}});
    rows.push_back('{31'd1, VMAX, 31'd1, VMAX, 1'b0, '0});
    rows.push_back('{31'h5555_5555, 31'h2AAA_AAAA, 31'h0000_FFFF, 31'h7FFF_0000, 1'b0, '0});
    // Edges (1,1) and (1,4097) share a bucket, so the second goes into the chain.
    rows.push_back('{31'd1, 31'd1, 31'd4097, 31'd8193, 1'b0, '0});
    rows.push_back('{31'd8193, 31'd4097, 31'd1, 31'd1, 1'b0, '0});
    rows.push_back('{31'd9, 31'd9, 31'd9, 31'd7, 1'b0, '0});
    foreach (rows[i]) begin
      r = rows[i];
      tet = '{r.a, r.b, r.c, r.d};
      send_tetra(tet);
      if (r.want_typed) begin
        void'(pending_edges.pop_back());
        pending_edges.push_back(r.want);
      end
    end
    for (int k = 0; k < ITEMS_PHASE; k++) send_tetra(random_tetra(50));

    // Random phases across sizes, the smallest (where the overflow area soon runs out)
    // and the clamped extremes among them.
    foreach (sizes[p]) begin
      write_hash_size(sizes[p]);
      for (int k = 0; k < ITEMS_PHASE; k++) send_tetra(random_tetra(pools[p]));
    end

    in_valid <= 1'b0;
    waited = 0;
    while (pending_edges.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_LEN) @(posedge clk);
    if (mismatches == 0 && pending_edges.size() == 0) begin
      $display("tb_mesh_edge_dedup_hash OK");
    end else begin
      $display("tb_mesh_edge_dedup_hash NOT OK");
    end
    $finish;
  end

endmodule
